### rtl/core/distance_vector_route_update_unit_macros.svh
// ----------------------------------------------------------------------------
// distance vector route update unit - assertion macros
// shared clocking and reset handling for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_UNIT_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_UNIT_MACROS_SVH

// property checked at every edge outside reset
`define DVRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DVRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/dvru_pkg.sv
// ----------------------------------------------------------------------------
// dvru_pkg
// types and codes shared by the route update unit and its parts
// ----------------------------------------------------------------------------
package dvru_pkg;

  localparam int ID_W      = 8;
  localparam int DIST_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int ROW_IDX_W = 5;

  // request kinds
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_VEC = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STS_IMPROVED  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_UNCHANGED = 3'd2;
  localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_UNKNOWN   = 3'd4;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]   dest;
    logic [DIST_W-1:0] metric;
    logic [ID_W-1:0]   hop;
  } route_row_t;

  typedef enum logic [1:0] {
    ALU_EQ,
    ALU_LT,
    ALU_ADD_SAT
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [DIST_W-1:0] a;
    logic [DIST_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] res;
    logic              flag;
  } alu_rsp_t;

endpackage

### rtl/core/dvru_alu.sv
// ----------------------------------------------------------------------------
// dvru_alu
// shared compare and saturating add unit used by the scan sequencer
// ----------------------------------------------------------------------------
module dvru_alu (
  input  dvru_pkg::alu_req_t req_i,
  output dvru_pkg::alu_rsp_t rsp_o
);
  import dvru_pkg::*;

  logic [DIST_W:0] sum;

  always_comb begin
    sum   = {1'b0, req_i.a} + {1'b0, req_i.b};
    rsp_o = '0;
    case (req_i.op)
      ALU_EQ: begin
        rsp_o.flag = (req_i.a == req_i.b);
      end
      ALU_LT: begin
        rsp_o.flag = (req_i.a < req_i.b);
      end
      ALU_ADD_SAT: begin
        // clamp at the top of the distance range
        rsp_o.res = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

endmodule

### rtl/core/dvru_route_mem.sv
// ----------------------------------------------------------------------------
// dvru_route_mem
// routing table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module dvru_route_mem #(
  parameter int ROWS = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(ROWS)-1:0]  wr_addr_i,
  input  dvru_pkg::route_row_t     wr_row_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(ROWS)-1:0]  rd_addr_i,
  output dvru_pkg::route_row_t     rd_row_o
);
  import dvru_pkg::*;

  route_row_t mem_q [ROWS];
  route_row_t rd_row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_row_o = rd_row_q;

endmodule

### rtl/core/distance_vector_route_update_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update_unit
// neighbour table and routing table with distance vector route updates
// ----------------------------------------------------------------------------
// requests arrive on the s_axis channel, one result per request leaves on
// m_axis. tuser of a request selects add neighbour or vector entry.
// an add neighbour request writes both tables on acceptance, then passes
// its result through the result stage into the output register.
// a vector entry walks the neighbour rows one per cycle through the shared
// compare unit, then streams the routing table through its registered read
// port one row per cycle.
// the block takes one request at a time; s_axis_tready is high only while
// the sequencer is idle. a finished result sits in the output register, so
// the next request is taken while the receiver stalls; that request then
// waits in its result stage until the output register frees.
// reset empties both tables by clearing their row counts; the row storage
// itself is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module distance_vector_route_update_unit #(
  parameter int ROUTE_ROWS    = 32,
  parameter int NEIGHBOR_ROWS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // node_id[7:0], dest_id[15:8], dist_value[31:16]
  input  logic [0:0]  s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // row_index[4:0], route_dist[20:5],
                                      // route_next_hop[28:21], zero[31:29]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);
  import dvru_pkg::*;

`include "distance_vector_route_update_unit_macros.svh"

  localparam int RAW = $clog2(ROUTE_ROWS);
  localparam int RCW = $clog2(ROUTE_ROWS + 1);
  localparam int NIW = (NEIGHBOR_ROWS > 1) ? $clog2(NEIGHBOR_ROWS) : 1;
  localparam int NCW = $clog2(NEIGHBOR_ROWS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NSCAN = 3'd1;
  localparam logic [2:0] ST_RSCAN = 3'd2;
  localparam logic [2:0] ST_RCMP  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [NCW-1:0]       nb_cnt_q, nb_cnt_d;
  logic [RCW-1:0]       rt_cnt_q, rt_cnt_d;
  logic                 m_valid_q, m_valid_d;

  logic [ID_W-1:0]      node_q, node_d;
  logic [ID_W-1:0]      dest_q, dest_d;
  logic [DIST_W-1:0]    dist_q, dist_d;
  logic [DIST_W-1:0]    cost_q, cost_d;
  logic [DIST_W-1:0]    sum_q, sum_d;
  logic                 known_q, known_d;
  logic [NCW-1:0]       nidx_q, nidx_d;
  logic [RCW-1:0]       raddr_q, raddr_d;
  logic [RAW-1:0]       cmp_q, cmp_d;
  logic                 rd_vld_q, rd_vld_d;

  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [ROW_IDX_W-1:0] res_row_q, res_row_d;
  logic [DIST_W-1:0]    res_dist_q, res_dist_d;
  logic [ID_W-1:0]      res_hop_q, res_hop_d;

  logic [STATUS_W-1:0]  m_status_q, m_status_d;
  logic [ROW_IDX_W-1:0] m_row_q, m_row_d;
  logic [DIST_W-1:0]    m_dist_q, m_dist_d;
  logic [ID_W-1:0]      m_hop_q, m_hop_d;

  logic [ID_W-1:0]      nb_id_q   [NEIGHBOR_ROWS];
  logic [DIST_W-1:0]    nb_cost_q [NEIGHBOR_ROWS];
  logic                 nb_we;

  logic                 mem_we;
  logic [RAW-1:0]       mem_waddr;
  route_row_t           mem_wrow;
  logic                 mem_re;
  route_row_t           rd_row;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  logic                 nb_full;
  logic                 rt_full;
  logic [ID_W-1:0]      in_node;
  logic [DIST_W-1:0]    in_dist;

  assign nb_full = (nb_cnt_q == NCW'(NEIGHBOR_ROWS));
  assign rt_full = (rt_cnt_q == RCW'(ROUTE_ROWS));
  assign in_node = s_axis_tdata[7:0];
  assign in_dist = s_axis_tdata[31:16];

  assign s_axis_tready = (state_q == ST_IDLE);

  dvru_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  dvru_route_mem #(
    .ROWS (ROUTE_ROWS)
  ) u_route_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_row_i  (mem_wrow),
    .rd_en_i   (mem_re),
    .rd_addr_i (raddr_q[RAW-1:0]),
    .rd_row_o  (rd_row)
  );

  always_comb begin
    state_d      = state_q;
    nb_cnt_d     = nb_cnt_q;
    rt_cnt_d     = rt_cnt_q;
    m_valid_d    = m_valid_q;
    node_d       = node_q;
    dest_d       = dest_q;
    dist_d       = dist_q;
    cost_d       = cost_q;
    sum_d        = sum_q;
    known_d      = known_q;
    nidx_d       = nidx_q;
    raddr_d      = raddr_q;
    cmp_d        = cmp_q;
    rd_vld_d     = rd_vld_q;
    res_status_d = res_status_q;
    res_row_d    = res_row_q;
    res_dist_d   = res_dist_q;
    res_hop_d    = res_hop_q;
    m_status_d   = m_status_q;
    m_row_d      = m_row_q;
    m_dist_d     = m_dist_q;
    m_hop_d      = m_hop_q;
    nb_we        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = rt_cnt_q[RAW-1:0];
    mem_wrow     = '0;
    mem_re       = 1'b0;
    alu_req      = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          node_d = in_node;
          dest_d = s_axis_tdata[15:8];
          dist_d = in_dist;
          if (s_axis_tuser[0] == REQ_ADD) begin
            if (nb_full || rt_full) begin
              res_status_d = STS_FULL;
              res_row_d    = '0;
              res_dist_d   = '0;
              res_hop_d    = '0;
            end else begin
              // direct route to the new neighbour
              nb_we           = 1'b1;
              mem_we          = 1'b1;
              mem_wrow.dest   = in_node;
              mem_wrow.metric = in_dist;
              mem_wrow.hop    = in_node;
              res_status_d    = STS_ADDED;
              res_row_d       = ROW_IDX_W'(rt_cnt_q);
              res_dist_d      = in_dist;
              res_hop_d       = in_node;
              nb_cnt_d        = nb_cnt_q + 1'b1;
              rt_cnt_d        = rt_cnt_q + 1'b1;
            end
            state_d = ST_RESP;
          end else begin
            nidx_d  = '0;
            known_d = 1'b0;
            state_d = ST_NSCAN;
          end
        end
      end

      ST_NSCAN: begin
        if (nidx_q < nb_cnt_q) begin
          alu_req.op = ALU_EQ;
          alu_req.a  = DIST_W'(nb_id_q[nidx_q[NIW-1:0]]);
          alu_req.b  = DIST_W'(node_q);
          // later duplicates overwrite, so the last match wins
          if (alu_rsp.flag) begin
            known_d = 1'b1;
            cost_d  = nb_cost_q[nidx_q[NIW-1:0]];
          end
          nidx_d = nidx_q + 1'b1;
        end else if (!known_q) begin
          res_status_d = STS_UNKNOWN;
          res_row_d    = '0;
          res_dist_d   = '0;
          res_hop_d    = '0;
          state_d      = ST_RESP;
        end else begin
          alu_req.op = ALU_ADD_SAT;
          alu_req.a  = cost_q;
          alu_req.b  = dist_q;
          sum_d      = alu_rsp.res;
          raddr_d    = '0;
          rd_vld_d   = 1'b0;
          state_d    = ST_RSCAN;
        end
      end

      ST_RSCAN: begin
        alu_req.op = ALU_EQ;
        alu_req.a  = DIST_W'(rd_row.dest);
        alu_req.b  = DIST_W'(dest_q);
        if (rd_vld_q && alu_rsp.flag) begin
          // first match: read data stays put for the distance compare
          rd_vld_d = 1'b0;
          state_d  = ST_RCMP;
        end else if (!rd_vld_q && (raddr_q >= rt_cnt_q)) begin
          if (rt_full) begin
            res_status_d = STS_FULL;
            res_row_d    = '0;
            res_dist_d   = '0;
            res_hop_d    = '0;
          end else begin
            mem_we          = 1'b1;
            mem_wrow.dest   = dest_q;
            mem_wrow.metric = sum_q;
            mem_wrow.hop    = node_q;
            res_status_d    = STS_INSERTED;
            res_row_d       = ROW_IDX_W'(rt_cnt_q);
            res_dist_d      = sum_q;
            res_hop_d       = node_q;
            rt_cnt_d        = rt_cnt_q + 1'b1;
          end
          state_d = ST_RESP;
        end else if (raddr_q < rt_cnt_q) begin
          mem_re   = 1'b1;
          cmp_d    = raddr_q[RAW-1:0];
          raddr_d  = raddr_q + 1'b1;
          rd_vld_d = 1'b1;
        end else begin
          rd_vld_d = 1'b0;
        end
      end

      ST_RCMP: begin
        alu_req.op = ALU_LT;
        alu_req.a  = sum_q;
        alu_req.b  = rd_row.metric;
        res_row_d  = ROW_IDX_W'(cmp_q);
        if (alu_rsp.flag) begin
          mem_we          = 1'b1;
          mem_waddr       = cmp_q;
          mem_wrow.dest   = dest_q;
          mem_wrow.metric = sum_q;
          mem_wrow.hop    = node_q;
          res_status_d    = STS_IMPROVED;
          res_dist_d      = sum_q;
          res_hop_d       = node_q;
        end else begin
          res_status_d  = STS_UNCHANGED;
          res_dist_d    = rd_row.metric;
          res_hop_d     = rd_row.hop;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_row_d    = res_row_q;
          m_dist_d   = res_dist_q;
          m_hop_d    = res_hop_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      nb_cnt_q  <= '0;
      rt_cnt_q  <= '0;
      m_valid_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      nb_cnt_q  <= nb_cnt_d;
      rt_cnt_q  <= rt_cnt_d;
      m_valid_q <= m_valid_d;
      rd_vld_q  <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q       <= node_d;
    dest_q       <= dest_d;
    dist_q       <= dist_d;
    cost_q       <= cost_d;
    sum_q        <= sum_d;
    known_q      <= known_d;
    nidx_q       <= nidx_d;
    raddr_q      <= raddr_d;
    cmp_q        <= cmp_d;
    res_status_q <= res_status_d;
    res_row_q    <= res_row_d;
    res_dist_q   <= res_dist_d;
    res_hop_q    <= res_hop_d;
    m_status_q   <= m_status_d;
    m_row_q      <= m_row_d;
    m_dist_q     <= m_dist_d;
    m_hop_q      <= m_hop_d;
    if (nb_we) begin
      nb_id_q[nb_cnt_q[NIW-1:0]]   <= in_node;
      nb_cost_q[nb_cnt_q[NIW-1:0]] <= in_dist;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_hop_q, m_dist_q, m_row_q};
  assign m_axis_tuser  = m_status_q;

  `DVRU_ASSERT(a_nb_cnt_range, nb_cnt_q <= NCW'(NEIGHBOR_ROWS), "neighbour count overflow")
  `DVRU_ASSERT(a_rt_cnt_range, rt_cnt_q <= RCW'(ROUTE_ROWS), "route count overflow")
  `DVRU_ASSERT_NEXT(a_rt_cnt_hold, !mem_we, rt_cnt_q == $past(rt_cnt_q), "route count moved without a write")
  `DVRU_ASSERT(a_improve_lower, (state_q == ST_RCMP) && mem_we |-> sum_q < rd_row.metric, "row replaced without a lower distance")

endmodule
